/* sv/scvgm_pkg.sv */
// Shared types and constants of the VGM command stream encoder.
// Holds the command descriptor passed from the front end to the back end.
package scvgm_pkg;

    // Kinds of bus events
    typedef enum logic [1:0] {
        KIND_IO   = 2'd0,
        KIND_MEM  = 2'd1,
        KIND_TICK = 2'd2,
        KIND_END  = 2'd3
    } t_kind;

    // Wait flush threshold in samples
    localparam logic [15:0] WAIT_LIMIT = 16'd65535;

    // Depth of the descriptor queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Maximum number of body bytes of one command
    localparam int BODY_BYTES = 4;

    // VGM command codes
    localparam logic [7:0] CMD_WAIT   = 8'h61;
    localparam logic [7:0] CMD_FM     = 8'h51;
    localparam logic [7:0] CMD_OPL    = 8'h5C;
    localparam logic [7:0] CMD_PSG    = 8'hA0;
    localparam logic [7:0] CMD_DAC    = 8'h50;
    localparam logic [7:0] CMD_STEREO = 8'h4F;
    localparam logic [7:0] CMD_WAVE   = 8'hD2;
    localparam logic [7:0] CMD_END    = 8'h66;

    // Wavetable init command payload
    localparam logic [7:0] WAVE_INIT_PORT = 8'h03;
    localparam logic [7:0] WAVE_INIT_OFS  = 8'h00;
    localparam logic [7:0] WAVE_INIT_DATA = 8'h1F;

    // One queued command: optional wait, optional wave init, then the body
    typedef struct packed {
        logic                       has_wait;
        logic [15:0]                wait_cnt;
        logic                       has_init;
        logic [2:0]                 body_len;
        logic [BODY_BYTES-1:0][7:0] body;
    } t_cmd;

endpackage

/* sv/sound_chip_write_to_vgm_encoder_top.sv */
// Bus event to VGM command stream encoder, top level.
// The first byte of an item passes the queue, the sequencer and the output register.
// Bytes stream at one per cycle while the receiver is ready; an item causes 1 to 11
// bytes or none, and items that cause no byte never queue.
// Items are taken while the two-entry descriptor queue has room.
// Synchronous reset clears latched addresses, wait count, init flag, queue and output.
module sound_chip_write_to_vgm_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    import scvgm_pkg::*;

    logic push, full, pop, empty;
    t_cmd push_cmd, pop_cmd;

    // Classify incoming items
    scvgm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_kind    (i_kind),
        .i_address (i_address),
        .i_data    (i_data),
        .i_full    (full),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    // Buffer descriptors between the two halves
    scvgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (empty)
    );

    // Serialize commands into bytes
    scvgm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_cmd      (pop_cmd),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

/* sv/scvgm_front.sv */
// Front end: accepts bus events, tracks latched addresses and the sample count,
// and turns each event into a command descriptor. Depends on scvgm_pkg.
module scvgm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_kind,
    input  logic [15:0]      i_address,
    input  logic [7:0]       i_data,
    input  logic             i_full,
    output logic             o_push,
    output scvgm_pkg::t_cmd  o_cmd
);
    import scvgm_pkg::*;

    // I/O port numbers
    localparam logic [7:0] PORT_FM_ADR0  = 8'h7C;
    localparam logic [7:0] PORT_FM_ADR1  = 8'hF0;
    localparam logic [7:0] PORT_FM_DAT0  = 8'h7D;
    localparam logic [7:0] PORT_FM_DAT1  = 8'hF1;
    localparam logic [7:0] PORT_OPL_ADR  = 8'hC0;
    localparam logic [7:0] PORT_OPL_DAT  = 8'hC1;
    localparam logic [7:0] PORT_PSG_ADR  = 8'hA0;
    localparam logic [7:0] PORT_PSG_DAT  = 8'hA1;
    localparam logic [7:0] PORT_DAC0     = 8'h7E;
    localparam logic [7:0] PORT_DAC1     = 8'h7F;
    localparam logic [7:0] PORT_STEREO   = 8'h06;

    // Memory window pages
    localparam logic [7:0] PLAIN_PAGE = 8'h98;
    localparam logic [7:0] PLUS_PAGE  = 8'hB8;

    typedef struct packed {
        logic       hit;
        logic [2:0] port;
        logic [7:0] ofs;
    } t_wave;

    // Decode an offset of the plain wavetable window
    function automatic t_wave plain_decode(input logic [7:0] a);
        t_wave w;
        w = '0;
        w.hit = 1'b1;
        if (a <= 8'h7F) begin
            w.port = 3'd0; w.ofs = a;
        end else if (a <= 8'h89) begin
            w.port = 3'd1; w.ofs = a - 8'h80;
        end else if (a <= 8'h8E) begin
            w.port = 3'd2; w.ofs = a - 8'h8A;
        end else if (a == 8'h8F) begin
            w.port = 3'd3;
        end else if (a <= 8'h99) begin
            w.port = 3'd1; w.ofs = a - 8'h90;
        end else if (a <= 8'h9E) begin
            w.port = 3'd2; w.ofs = a - 8'h9A;
        end else if (a == 8'h9F) begin
            w.port = 3'd3;
        end else if (a >= 8'hE0) begin
            w.port = 3'd5; w.ofs = a - 8'hE0;
        end else begin
            w.hit = 1'b0;
        end
        return w;
    endfunction

    // Decode an offset of the extended wavetable window
    function automatic t_wave plus_decode(input logic [7:0] a);
        t_wave w;
        w = '0;
        w.hit = 1'b1;
        if (a <= 8'h7F) begin
            w.port = 3'd0; w.ofs = a;
        end else if (a <= 8'h9F) begin
            w.port = 3'd4; w.ofs = a;
        end else if (a <= 8'hA9) begin
            w.port = 3'd1; w.ofs = a - 8'hA0;
        end else if (a <= 8'hAE) begin
            w.port = 3'd2; w.ofs = a - 8'hAA;
        end else if (a == 8'hAF) begin
            w.port = 3'd3;
        end else if (a <= 8'hB9) begin
            w.port = 3'd1; w.ofs = a - 8'hB0;
        end else if (a <= 8'hBE) begin
            w.port = 3'd2; w.ofs = a - 8'hBA;
        end else if (a == 8'hBF) begin
            w.port = 3'd3;
        end else if (a <= 8'hDF) begin
            w.port = 3'd5; w.ofs = a - 8'hC0;
        end else begin
            w.hit = 1'b0;
        end
        return w;
    endfunction

    logic [7:0]  r_fm_adr, n_fm_adr;
    logic [7:0]  r_opl_adr, n_opl_adr;
    logic [7:0]  r_psg_adr, n_psg_adr;
    logic        r_started, n_started;
    logic [15:0] r_pend, n_pend;

    logic        accept;
    logic        push;
    t_cmd        cmd;
    t_wave       wave;
    logic [7:0]  port_lo;
    logic [15:0] pend_inc;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign port_lo = i_address[7:0];
    assign pend_inc = r_pend + 16'd1;

    // Classify the item and build its descriptor
    always_comb begin
        n_fm_adr  = r_fm_adr;
        n_opl_adr = r_opl_adr;
        n_psg_adr = r_psg_adr;
        n_started = r_started;
        n_pend    = r_pend;
        push      = 1'b0;
        cmd       = '0;
        cmd.has_wait = (r_pend != 16'd0);
        cmd.wait_cnt = r_pend;
        wave      = '0;

        case (i_kind)
            KIND_IO: begin
                case (port_lo)
                    PORT_FM_ADR0, PORT_FM_ADR1: n_fm_adr = i_data;
                    PORT_OPL_ADR: n_opl_adr = i_data;
                    PORT_PSG_ADR: n_psg_adr = i_data;
                    PORT_FM_DAT0, PORT_FM_DAT1: begin
                        push = 1'b1;
                        cmd.body_len = 3'd3;
                        cmd.body[0] = CMD_FM;
                        cmd.body[1] = r_fm_adr;
                        cmd.body[2] = i_data;
                        n_pend = '0;
                    end
                    PORT_OPL_DAT: begin
                        push = 1'b1;
                        cmd.body_len = 3'd3;
                        cmd.body[0] = CMD_OPL;
                        cmd.body[1] = r_opl_adr;
                        cmd.body[2] = i_data;
                        n_pend = '0;
                    end
                    PORT_PSG_DAT: begin
                        push = 1'b1;
                        cmd.body_len = 3'd3;
                        cmd.body[0] = CMD_PSG;
                        cmd.body[1] = r_psg_adr;
                        cmd.body[2] = i_data;
                        n_pend = '0;
                    end
                    PORT_DAC0, PORT_DAC1: begin
                        push = 1'b1;
                        cmd.body_len = 3'd2;
                        cmd.body[0] = CMD_DAC;
                        cmd.body[1] = i_data;
                        n_pend = '0;
                    end
                    PORT_STEREO: begin
                        push = 1'b1;
                        cmd.body_len = 3'd2;
                        cmd.body[0] = CMD_STEREO;
                        cmd.body[1] = i_data;
                        n_pend = '0;
                    end
                    default: ;
                endcase
            end
            KIND_MEM: begin
                if (i_address[15:8] == PLAIN_PAGE) begin
                    wave = plain_decode(port_lo);
                end else if (i_address[15:8] == PLUS_PAGE) begin
                    wave = plus_decode(port_lo);
                end
                if (wave.hit) begin
                    push = 1'b1;
                    cmd.has_init = !r_started;
                    cmd.body_len = 3'd4;
                    cmd.body[0] = CMD_WAVE;
                    cmd.body[1] = {5'd0, wave.port};
                    cmd.body[2] = wave.ofs;
                    cmd.body[3] = i_data;
                    n_started = 1'b1;
                    n_pend = '0;
                end
            end
            KIND_TICK: begin
                // Flush a full wait as soon as the count reaches the limit
                if (pend_inc >= WAIT_LIMIT) begin
                    push = 1'b1;
                    cmd.has_wait = 1'b1;
                    cmd.wait_cnt = WAIT_LIMIT;
                    n_pend = '0;
                end else begin
                    n_pend = pend_inc;
                end
            end
            KIND_END: begin
                push = 1'b1;
                cmd.body_len = 3'd1;
                cmd.body[0] = CMD_END;
                n_pend = '0;
            end
            default: ;
        endcase
    end

    assign o_push = push && accept;
    assign o_cmd  = cmd;

    // Update tracked state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fm_adr  <= '0;
            r_opl_adr <= '0;
            r_psg_adr <= '0;
            r_started <= 1'b0;
            r_pend    <= '0;
        end else if (accept) begin
            r_fm_adr  <= n_fm_adr;
            r_opl_adr <= n_opl_adr;
            r_psg_adr <= n_psg_adr;
            r_started <= n_started;
            r_pend    <= n_pend;
        end
    end

endmodule

/* sv/scvgm_queue.sv */
// Short descriptor queue between front and back end.
// Depends on scvgm_pkg for the descriptor type and depth.
module scvgm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  scvgm_pkg::t_cmd  i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output scvgm_pkg::t_cmd  o_cmd,
    output logic             o_empty
);
    import scvgm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    // Store pushed descriptors
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

/* sv/scvgm_back.sv */
// Back end: serializes queued descriptors into VGM bytes, one per cycle while the
// receiver is ready, through a registered output stage. Depends on scvgm_pkg.
module scvgm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  scvgm_pkg::t_cmd  i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last
);
    import scvgm_pkg::*;

    typedef enum logic [1:0] {
        P_IDLE,
        P_WAIT,
        P_INIT,
        P_BODY
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [1:0] r_idx, n_idx;
    t_cmd       r_cur, n_cur;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;

    logic       slot_free;
    logic       busy;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       pop;

    // Pick the opening phase of a descriptor
    function automatic t_phase first_phase(input t_cmd c);
        t_phase p;
        if (c.has_wait) begin
            p = P_WAIT;
        end else if (c.has_init) begin
            p = P_INIT;
        end else begin
            p = P_BODY;
        end
        return p;
    endfunction

    assign slot_free = !r_out_valid || i_ready;
    assign busy      = (r_phase != P_IDLE);

    // Select the byte at the current position and flag the final one
    always_comb begin
        cur_byte = '0;
        cur_last = 1'b0;
        case (r_phase)
            P_WAIT: begin
                case (r_idx)
                    2'd0: cur_byte = CMD_WAIT;
                    2'd1: cur_byte = r_cur.wait_cnt[7:0];
                    default: cur_byte = r_cur.wait_cnt[15:8];
                endcase
                cur_last = (r_idx == 2'd2) && !r_cur.has_init && (r_cur.body_len == 3'd0);
            end
            P_INIT: begin
                case (r_idx)
                    2'd0: cur_byte = CMD_WAVE;
                    2'd1: cur_byte = WAVE_INIT_PORT;
                    2'd2: cur_byte = WAVE_INIT_OFS;
                    default: cur_byte = WAVE_INIT_DATA;
                endcase
                cur_last = (r_idx == 2'd3) && (r_cur.body_len == 3'd0);
            end
            P_BODY: begin
                cur_byte = r_cur.body[r_idx];
                cur_last = ({1'b0, r_idx} == (r_cur.body_len - 3'd1));
            end
            default: ;
        endcase
    end

    // Sequence through wait, init and body bytes; fetch the next descriptor
    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        pop         = 1'b0;

        if (slot_free) begin
            n_out_valid = busy;
            n_out_byte  = cur_byte;
            n_out_last  = cur_last;
        end

        if (busy && slot_free) begin
            if (cur_last) begin
                if (!i_empty) begin
                    pop     = 1'b1;
                    n_cur   = i_cmd;
                    n_phase = first_phase(i_cmd);
                    n_idx   = '0;
                end else begin
                    n_phase = P_IDLE;
                    n_idx   = '0;
                end
            end else if (r_phase == P_WAIT && r_idx == 2'd2) begin
                n_phase = r_cur.has_init ? P_INIT : P_BODY;
                n_idx   = '0;
            end else if (r_phase == P_INIT && r_idx == 2'd3) begin
                n_phase = P_BODY;
                n_idx   = '0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end else if (!busy && !i_empty) begin
            pop     = 1'b1;
            n_cur   = i_cmd;
            n_phase = first_phase(i_cmd);
            n_idx   = '0;
        end
    end

    assign o_pop      = pop;
    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

    // Hold sequencer state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_cur      <= n_cur;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the bus event to VGM command stream encoder.
// Depends on scvgm_pkg and sound_chip_write_to_vgm_encoder_top; predicts the byte stream itself.
// Drives a directed table, a short tick run, then random events under three idle patterns.
module tb_top;
    import scvgm_pkg::*;

    // Bus ports that the encoder decodes
    localparam logic [7:0] PORT_FM_ADR      = 8'h7C;
    localparam logic [7:0] PORT_FM_ADR_ALT  = 8'hF0;
    localparam logic [7:0] PORT_FM_DATA     = 8'h7D;
    localparam logic [7:0] PORT_FM_DATA_ALT = 8'hF1;
    localparam logic [7:0] PORT_OPL_ADR     = 8'hC0;
    localparam logic [7:0] PORT_OPL_DATA    = 8'hC1;
    localparam logic [7:0] PORT_PSG_ADR     = 8'hA0;
    localparam logic [7:0] PORT_PSG_DATA    = 8'hA1;
    localparam logic [7:0] PORT_DAC         = 8'h7E;
    localparam logic [7:0] PORT_DAC_ALT     = 8'h7F;
    localparam logic [7:0] PORT_STEREO      = 8'h06;
    localparam logic [7:0] IO_PORTS [11] = '{PORT_FM_ADR, PORT_FM_ADR_ALT, PORT_FM_DATA,
        PORT_FM_DATA_ALT, PORT_OPL_ADR, PORT_OPL_DATA, PORT_PSG_ADR, PORT_PSG_DATA,
        PORT_DAC, PORT_DAC_ALT, PORT_STEREO};

    // Wavetable memory windows (high address byte) and their port codes
    localparam logic [7:0] WIN_PLAIN     = 8'h98;
    localparam logic [7:0] WIN_PLUS      = 8'hB8;
    localparam logic [7:0] WP_WAVE       = 8'd0;
    localparam logic [7:0] WP_FREQ       = 8'd1;
    localparam logic [7:0] WP_VOL        = 8'd2;
    localparam logic [7:0] WP_ENABLE     = 8'd3;
    localparam logic [7:0] WP_WAVE_PLUS  = 8'd4;
    localparam logic [7:0] WP_TEST       = 8'd5;

    localparam int PREDICT      = -1;
    localparam int PHASE_ITEMS  = 150;
    localparam int TICK_RUN     = 20;
    localparam int STALL_LIMIT  = 5000;
    localparam int RX_HOLD      = 300;
    localparam int TAIL_CYCLES  = 20;

    // One directed event; typed bytes are read from the top byte down
    typedef struct packed {
        t_kind       kind;
        logic [15:0] addr;
        logic [7:0]  data;
        int          n_typed;
        logic [31:0] typed;
    } t_row;

    localparam t_row DIRECTED_ROWS [25] = '{
        '{KIND_END,  16'h0000, 8'h00, 1,       32'h6600_0000},
        '{KIND_IO,   16'h007D, 8'hFF, 3,       32'h5100_FF00},
        '{KIND_IO,   16'h00C1, 8'h00, 3,       32'h5C00_0000},
        '{KIND_IO,   16'h00A1, 8'h80, 3,       32'hA000_8000},
        '{KIND_IO,   16'h007C, 8'hAB, 0,       32'h0},
        '{KIND_IO,   16'hFFF1, 8'h01, PREDICT, 32'h0},
        '{KIND_IO,   16'h00F0, 8'h55, 0,       32'h0},
        '{KIND_IO,   16'h00C0, 8'hFF, 0,       32'h0},
        '{KIND_IO,   16'h00A0, 8'h7F, 0,       32'h0},
        '{KIND_IO,   16'h8DC1, 8'h34, PREDICT, 32'h0},
        '{KIND_IO,   16'h00A1, 8'h01, PREDICT, 32'h0},
        '{KIND_IO,   16'h007E, 8'h00, 2,       32'h5000_0000},
        '{KIND_IO,   16'h007F, 8'hFF, 2,       32'h50FF_0000},
        '{KIND_IO,   16'h0006, 8'hAA, 2,       32'h4FAA_0000},
        '{KIND_IO,   16'h0000, 8'hFF, 0,       32'h0},
        '{KIND_TICK, 16'hFFFF, 8'hFF, 0,       32'h0},
        '{KIND_TICK, 16'h0000, 8'h00, 0,       32'h0},
        '{KIND_IO,   16'h007C, 8'h12, 0,       32'h0},
        '{KIND_MEM,  16'h1234, 8'h5A, 0,       32'h0},
        '{KIND_MEM,  16'h98A0, 8'h11, 0,       32'h0},
        '{KIND_MEM,  16'h9800, 8'h00, PREDICT, 32'h0},
        '{KIND_MEM,  16'h98FF, 8'hFF, 4,       32'hD205_1FFF},
        '{KIND_MEM,  16'hB89A, 8'h77, 4,       32'hD204_9A77},
        '{KIND_MEM,  16'hB8BE, 8'h01, PREDICT, 32'h0},
        '{KIND_MEM,  16'h9895, 8'h3C, PREDICT, 32'h0}
    };

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_stream_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_kind;
    logic [15:0] i_address;
    logic [7:0]  i_data;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_byte;
    logic        o_last;

    sound_chip_write_to_vgm_encoder_top dut (.*);

    // Predicted encoder state
    logic [7:0]  fm_adr;
    logic [7:0]  opl_adr;
    logic [7:0]  psg_adr;
    logic        wave_on;
    logic [15:0] pend_wait;

    logic [7:0]   cmd_bytes [$];
    t_stream_byte vgm_stream_q [$];

    int error_count  = 0;
    int stall_cycles = 0;
    int tx_idle_pct  = 21;
    int rx_idle_pct  = 85;
    int idle_phase   = 0;

    function automatic void note_error(string what);
        error_count++;
        if (error_count <= 10) $display("ERROR: %s", what);
    endfunction

    function automatic void put(logic [7:0] b);
        cmd_bytes.push_back(b);
    endfunction

    function automatic void put_wait(logic [15:0] n);
        put(CMD_WAIT);
        put(n[7:0]);
        put(n[15:8]);
    endfunction

    function automatic void flush_wait();
        if (pend_wait != 16'd0) begin
            put_wait(pend_wait);
            pend_wait = 16'd0;
        end
    endfunction

    function automatic void chip_cmd3(logic [7:0] op, logic [7:0] adr, logic [7:0] d);
        flush_wait();
        put(op);
        put(adr);
        put(d);
    endfunction

    // Map a window offset to a wavetable port; emit the one-time init ahead of the first write
    function automatic bit wave_write(logic plus, logic [7:0] lo, logic [7:0] d);
        logic [7:0] port;
        logic [7:0] off;
        bit         hit;
        hit = 1'b1;
        off = lo;
        port = WP_WAVE;
        if (!plus) begin
            if (lo <= 8'h7F) port = WP_WAVE;
            else if (lo <= 8'h89) begin port = WP_FREQ; off = lo - 8'h80; end
            else if (lo <= 8'h8E) begin port = WP_VOL; off = lo - 8'h8A; end
            else if (lo == 8'h8F) begin port = WP_ENABLE; off = 8'h00; end
            else if (lo <= 8'h99) begin port = WP_FREQ; off = lo - 8'h90; end
            else if (lo <= 8'h9E) begin port = WP_VOL; off = lo - 8'h9A; end
            else if (lo == 8'h9F) begin port = WP_ENABLE; off = 8'h00; end
            else if (lo >= 8'hE0) begin port = WP_TEST; off = lo - 8'hE0; end
            else hit = 1'b0;
        end else begin
            if (lo <= 8'h7F) port = WP_WAVE;
            else if (lo <= 8'h9F) port = WP_WAVE_PLUS;
            else if (lo <= 8'hA9) begin port = WP_FREQ; off = lo - 8'hA0; end
            else if (lo <= 8'hAE) begin port = WP_VOL; off = lo - 8'hAA; end
            else if (lo == 8'hAF) begin port = WP_ENABLE; off = 8'h00; end
            else if (lo <= 8'hB9) begin port = WP_FREQ; off = lo - 8'hB0; end
            else if (lo <= 8'hBE) begin port = WP_VOL; off = lo - 8'hBA; end
            else if (lo == 8'hBF) begin port = WP_ENABLE; off = 8'h00; end
            else if (lo <= 8'hDF) begin port = WP_TEST; off = lo - 8'hC0; end
            else hit = 1'b0;
        end
        if (hit) begin
            if (!wave_on) begin
                flush_wait();
                put(CMD_WAVE);
                put(WAVE_INIT_PORT);
                put(WAVE_INIT_OFS);
                put(WAVE_INIT_DATA);
                wave_on = 1'b1;
            end
            flush_wait();
            put(CMD_WAVE);
            put(port);
            put(off);
            put(d);
        end
        return hit;
    endfunction

    // Compute the command bytes of one event into cmd_bytes; flag events that do anything
    function automatic bit encode_event(t_kind k, logic [15:0] a, logic [7:0] d);
        logic [7:0] lo;
        bit         busy;
        lo = a[7:0];
        busy = 1'b1;
        cmd_bytes.delete();
        case (k)
            KIND_IO: begin
                case (lo)
                    PORT_FM_ADR, PORT_FM_ADR_ALT:   fm_adr = d;
                    PORT_FM_DATA, PORT_FM_DATA_ALT: chip_cmd3(CMD_FM, fm_adr, d);
                    PORT_OPL_ADR:                   opl_adr = d;
                    PORT_OPL_DATA:                  chip_cmd3(CMD_OPL, opl_adr, d);
                    PORT_PSG_ADR:                   psg_adr = d;
                    PORT_PSG_DATA:                  chip_cmd3(CMD_PSG, psg_adr, d);
                    PORT_DAC, PORT_DAC_ALT: begin
                        flush_wait();
                        put(CMD_DAC);
                        put(d);
                    end
                    PORT_STEREO: begin
                        flush_wait();
                        put(CMD_STEREO);
                        put(d);
                    end
                    default: busy = 1'b0;
                endcase
            end
            KIND_MEM: begin
                if (a[15:8] == WIN_PLAIN) busy = wave_write(1'b0, lo, d);
                else if (a[15:8] == WIN_PLUS) busy = wave_write(1'b1, lo, d);
                else busy = 1'b0;
            end
            KIND_TICK: begin
                pend_wait = pend_wait + 16'd1;
                if (pend_wait >= WAIT_LIMIT) begin
                    put_wait(WAIT_LIMIT);
                    pend_wait = 16'd0;
                end
            end
            default: begin
                flush_wait();
                put(CMD_END);
            end
        endcase
        return busy;
    endfunction

    // Offer one event from a falling edge, hold it until taken, then queue its bytes
    task automatic send_item(input t_kind k, input logic [15:0] a, input logic [7:0] d,
                             input int n_typed, input logic [31:0] typed, output bit busy);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_kind    = k;
        i_address = a;
        i_data    = d;
        do @(posedge i_clk); while (!o_ready);
        busy = encode_event(k, a, d);
        if (n_typed != PREDICT) begin
            cmd_bytes.delete();
            for (int i = 0; i < n_typed; i++) cmd_bytes.push_back(typed[31 - 8 * i -: 8]);
        end
        foreach (cmd_bytes[i])
            vgm_stream_q.push_back('{cmd_bytes[i], i == cmd_bytes.size() - 1});
        @(negedge i_clk);
    endtask

    // Pick a random event, mostly decoded ports and window hits; report the items sent
    task automatic send_random(input int budget, output int sent);
        int          pick;
        int          burst;
        logic [15:0] a;
        logic [7:0]  d;
        bit          busy;
        pick = $urandom_range(99);
        a = 16'($urandom);
        d = 8'($urandom);
        sent = 1;
        if (pick < 42) begin
            if ($urandom_range(99) < 85) a[7:0] = IO_PORTS[$urandom_range(10)];
            send_item(KIND_IO, a, d, PREDICT, 32'h0, busy);
        end else if (pick < 74) begin
            if ($urandom_range(99) < 80) a[15:8] = $urandom_range(1) ? WIN_PLAIN : WIN_PLUS;
            send_item(KIND_MEM, a, d, PREDICT, 32'h0, busy);
        end else if (pick < 90) begin
            send_item(KIND_TICK, a, d, PREDICT, 32'h0, busy);
        end else if (pick < 92) begin
            // long tick run so the wait count may carry a high byte
            burst = $urandom_range(300, 1);
            if (burst > budget) burst = budget;
            repeat (burst) send_item(KIND_TICK, 16'($urandom), 8'($urandom), PREDICT,
                                     32'h0, busy);
            sent = burst;
        end else begin
            send_item(KIND_END, a, d, PREDICT, 32'h0, busy);
        end
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (vgm_stream_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_random_phase();
        int done;
        int sent;
        done = 0;
        while (done < PHASE_ITEMS) begin
            send_random(PHASE_ITEMS - done, sent);
            done += sent;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive ready; hold off for a long stretch once the no-idle phase starts
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_phase == 2 && !hold_done) begin
                hold_left = RX_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else begin
                i_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare each delivered byte with the oldest prediction
    always @(posedge i_clk) begin
        t_stream_byte want;
        if (i_rst_n && o_valid && i_ready) begin
            if (vgm_stream_q.size() == 0) begin
                note_error($sformatf("unexpected byte %02h last %b", o_out_byte, o_last));
            end else begin
                want = vgm_stream_q.pop_front();
                if (o_out_byte !== want.value || o_last !== want.last)
                    note_error($sformatf("byte expected %02h last %b, got %02h last %b",
                                         want.value, want.last, o_out_byte, o_last));
            end
        end
    end

    // Stop a hung run: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        bit busy;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_kind    = KIND_IO;
        i_address = 16'h0000;
        i_data    = 8'h00;
        fm_adr    = 8'h00;
        opl_adr   = 8'h00;
        psg_adr   = 8'h00;
        wave_on   = 1'b0;
        pend_wait = 16'h0000;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table, then a short tick run whose remainder the end item flushes
        foreach (DIRECTED_ROWS[i])
            send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].data,
                      DIRECTED_ROWS[i].n_typed, DIRECTED_ROWS[i].typed, busy);
        repeat (TICK_RUN)
            send_item(KIND_TICK, 16'($urandom), 8'($urandom), PREDICT, 32'h0, busy);
        send_item(KIND_END, 16'h0000, 8'h00, PREDICT, 32'h0, busy);
        run_random_phase();
        wait_drained();

        // Swap idle rates between sender and receiver
        idle_phase  = 1;
        tx_idle_pct = 85;
        rx_idle_pct = 21;
        run_random_phase();
        wait_drained();

        // No idling; the receiver holds off at the start so the input stalls
        idle_phase  = 2;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase();
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && vgm_stream_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/scvgm_pkg.sv
sv/scvgm_front.sv
sv/scvgm_queue.sv
sv/scvgm_back.sv
sv/sound_chip_write_to_vgm_encoder_top.sv
verif/tb_top.sv
